// ----- hw/rtl/clush_pkg.sv -----
// Package: shared constants, register indexes and carry-less helpers for the string hash.
`default_nettype none
package clush_pkg;

   localparam int BLOCK_WORDS_DEFAULT = 128;
   localparam int KEY_DEPTH = 128;
   localparam int KEY_AW = 7;
   localparam int CSR_IW = 3;

   localparam logic [CSR_IW-1:0] CSR_POLY_LO = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_POLY_HI = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_FKEY_LO = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_FKEY_HI = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_LEN_KEY = 3'd4;

   localparam logic [63:0] POLY_HI_MASK = 64'h3fff_ffff_ffff_ffff;

   localparam logic [7:0] FOLD_TABLE [16] = '{
      8'd0, 8'd27, 8'd54, 8'd45, 8'd108, 8'd119, 8'd90, 8'd65,
      8'd216, 8'd195, 8'd238, 8'd245, 8'd180, 8'd175, 8'd130, 8'd153
   };

   // 32x32 carry-less product
   function automatic logic [63:0] clmul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (b[i]) begin
            r = r ^ ({32'd0, a} << i);
         end
      end
      return r;
   endfunction

   // reduction modulo x^64+x^4+x^3+x+1
   function automatic logic [63:0] reduce64(input logic [127:0] a);
      logic [127:0] q;
      logic [63:0] h;
      h = a[127:64];
      q = {64'd0, h} ^ ({64'd0, h} << 1) ^ ({64'd0, h} << 3) ^ ({64'd0, h} << 4);
      return q[63:0] ^ a[63:0] ^ {56'd0, FOLD_TABLE[q[67:64]]};
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/clush_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module clush_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- hw/rtl/carryless_universal_string_hash.sv -----
// Top level: keyed carry-less universal string hash over a key memory and a shared multiplier.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | cmd, key_index, word_data, valid_bytes, last_word
//   rsp     | out       | rsp_valid/rsp_stall  | hash_value
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// A message word at an even position is keyed and held; at an odd one it is multiplied
// with the held word: the key memory read passes ST_KREAD and ST_KWAIT, and each 64x64
// carry-less product takes 4 passes through one 32x32 multiplier. Block rollover and
// message end add the pair close and, as needed, the 4-product fold and final key and length products.
// Reset is synchronous; no clearing pass, the key memory is undefined until loaded.
// req_stall is high while an item is at work; a waiting result holds rsp until taken.
`default_nettype none
module carryless_universal_string_hash import clush_pkg::*; #(
   parameter int BLOCK_WORDS = BLOCK_WORDS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [6:0]        req_key_index,
   input  wire logic [63:0]       req_word_data,
   input  wire logic [3:0]        req_valid_bytes,
   input  wire logic              req_last_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [63:0]       rsp_hash_value,
   input  wire logic              csr_wr_en,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [63:0]       csr_wdata
);

   localparam int PW = $clog2(BLOCK_WORDS + 1);
   localparam logic [PW-1:0] POS_FULL = PW'(BLOCK_WORDS);

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_KREAD    = 14'b00000000000010,
      ST_KWAIT    = 14'b00000000000100,
      ST_POST     = 14'b00000000001000,
      ST_CB       = 14'b00000000010000,
      ST_CB_RD    = 14'b00000000100000,
      ST_CB_WAIT  = 14'b00000001000000,
      ST_CONT     = 14'b00000010000000,
      ST_FOLD     = 14'b00000100000000,
      ST_FOLD_END = 14'b00001000000000,
      ST_FINKEY   = 14'b00010000000000,
      ST_LEN      = 14'b00100000000000,
      ST_MUL      = 14'b01000000000000,
      ST_OUT      = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      JOB_WORD, JOB_CLOSE, JOB_FOLD, JOB_FINKEY, JOB_LEN
   } job_type;

   state_type state_ff, state_in;
   job_type job_ff, job_in;

   logic [63:0] poly_lo_ff, poly_hi_ff, fkey_lo_ff, fkey_hi_ff, len_key_ff;
   logic [127:0] acc_ff, acc_in, bsum_ff, bsum_in, total_ff, total_in;
   logic [63:0] held_ff, held_in, bytes_ff, bytes_in, word_ff, word_in;
   logic [3:0] vb_ff, vb_in;
   logic last_ff, last_in, fin_ff, fin_in, later_ff, later_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [1:0] mstep_ff, mstep_in, fcnt_ff, fcnt_in;
   logic [127:0] macc_ff, macc_in, flow_ff, flow_in, fhigh_ff, fhigh_in, fmix_ff, fmix_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;

   logic ram_we;
   logic [KEY_AW-1:0] ram_raddr;
   logic [63:0] ram_rdata;

   logic [63:0] part;
   logic [127:0] prod;
   logic [3:0] vbc;
   logic [63:0] wmask;
   logic [127:0] fl, fh, fold_r;
   logic [63:0] hl, hh;

   clush_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_key_index),
      .wr_data (req_word_data),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign part = clmul32(mstep_ff[0] ? ma_ff[63:32] : ma_ff[31:0],
                         mstep_ff[1] ? mb_ff[63:32] : mb_ff[31:0]);
   assign prod = macc_ff ^ ({64'd0, part} << (7'(mstep_ff[0]) + 7'(mstep_ff[1])) * 7'd32);

   assign vbc = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
   assign wmask = (vbc == 4'd8) ? '1 : ((64'd1 << (7'(vbc) * 7'd8)) - 64'd1);

   assign fl = flow_ff ^ {fmix_ff[63:0], 64'd0};
   assign fh = fhigh_ff ^ {64'd0, fmix_ff[127:64]};
   assign hl = fh[63:0];
   assign hh = fh[127:64];
   assign fold_r = {fl[127:64] ^ (hh << 1) ^ (hl >> 63) ^ (hh << 2) ^ (hl >> 62),
                    fl[63:0] ^ (hl << 1) ^ (hl << 2)};

   assign req_stall = (state_ff != ST_IDLE);
   assign ram_we = (state_ff == ST_IDLE) && req_valid && !req_cmd;
   assign ram_raddr = KEY_AW'(pos_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      acc_in = acc_ff;
      bsum_in = bsum_ff;
      total_in = total_ff;
      held_in = held_ff;
      bytes_in = bytes_ff;
      word_in = word_ff;
      vb_in = vb_ff;
      last_in = last_ff;
      fin_in = fin_ff;
      later_in = later_ff;
      pos_in = pos_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      mstep_in = mstep_ff;
      fcnt_in = fcnt_ff;
      macc_in = macc_ff;
      flow_in = flow_ff;
      fhigh_in = fhigh_ff;
      fmix_in = fmix_ff;
      rsp_hash_in = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd && !(vbc == 4'd0 && !req_last_word)) begin
               word_in = req_word_data & wmask;
               vb_in = vbc;
               last_in = req_last_word;
               if (vbc == 4'd0) begin
                  fin_in = 1'b1;
                  state_in = ST_CB;
               end else if (pos_ff >= POS_FULL) begin
                  fin_in = 1'b0;
                  state_in = ST_CB;
               end else begin
                  state_in = ST_KREAD;
               end
            end
         end
         ST_KREAD: begin
            state_in = ST_KWAIT;
         end
         ST_KWAIT: begin
            if (pos_ff[0]) begin
               ma_in = held_ff;
               mb_in = word_ff ^ ram_rdata;
               job_in = JOB_WORD;
               mstep_in = '0;
               macc_in = '0;
               state_in = ST_MUL;
            end else begin
               held_in = word_ff ^ ram_rdata;
               pos_in = pos_ff + PW'(1);
               bytes_in = bytes_ff + 64'(vb_ff);
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (last_ff) begin
               fin_in = 1'b1;
               state_in = ST_CB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CB: begin
            state_in = pos_ff[0] ? ST_CB_RD : ST_CONT;
         end
         ST_CB_RD: begin
            state_in = ST_CB_WAIT;
         end
         ST_CB_WAIT: begin
            ma_in = held_ff;
            mb_in = ram_rdata;
            job_in = JOB_CLOSE;
            mstep_in = '0;
            macc_in = '0;
            state_in = ST_MUL;
         end
         ST_CONT: begin
            if (later_ff) begin
               fcnt_in = '0;
               state_in = ST_FOLD;
            end else if (fin_ff) begin
               total_in = bsum_ff;
               state_in = ST_LEN;
            end else begin
               acc_in = bsum_ff;
               later_in = 1'b1;
               bsum_in = '0;
               pos_in = '0;
               state_in = ST_KREAD;
            end
         end
         ST_FOLD: begin
            ma_in = fcnt_ff[0] ? (poly_hi_ff & POLY_HI_MASK) : poly_lo_ff;
            mb_in = (fcnt_ff[0] ^ fcnt_ff[1]) ? acc_ff[127:64] : acc_ff[63:0];
            job_in = JOB_FOLD;
            mstep_in = '0;
            macc_in = '0;
            state_in = ST_MUL;
         end
         ST_FOLD_END: begin
            acc_in = fold_r ^ bsum_ff;
            if (fin_ff) begin
               state_in = ST_FINKEY;
            end else begin
               later_in = 1'b1;
               bsum_in = '0;
               pos_in = '0;
               state_in = ST_KREAD;
            end
         end
         ST_FINKEY: begin
            ma_in = acc_ff[63:0] ^ fkey_lo_ff;
            mb_in = acc_ff[127:64] ^ fkey_hi_ff;
            job_in = JOB_FINKEY;
            mstep_in = '0;
            macc_in = '0;
            state_in = ST_MUL;
         end
         ST_LEN: begin
            ma_in = bytes_ff;
            mb_in = len_key_ff;
            job_in = JOB_LEN;
            mstep_in = '0;
            macc_in = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            macc_in = prod;
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd3) begin
               case (job_ff)
                  JOB_WORD: begin
                     bsum_in = bsum_ff ^ prod;
                     pos_in = pos_ff + PW'(1);
                     bytes_in = bytes_ff + 64'(vb_ff);
                     state_in = ST_POST;
                  end
                  JOB_CLOSE: begin
                     bsum_in = bsum_ff ^ prod;
                     state_in = ST_CONT;
                  end
                  JOB_FOLD: begin
                     case (fcnt_ff)
                        2'd0: flow_in = prod;
                        2'd1: fhigh_in = prod;
                        2'd2: fmix_in = prod;
                        default: fmix_in = fmix_ff ^ prod;
                     endcase
                     fcnt_in = fcnt_ff + 2'd1;
                     state_in = (fcnt_ff == 2'd3) ? ST_FOLD_END : ST_FOLD;
                  end
                  JOB_FINKEY: begin
                     total_in = prod;
                     state_in = ST_LEN;
                  end
                  JOB_LEN: begin
                     total_in = total_ff ^ prod;
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_hash_in = reduce64(total_ff);
               rsp_valid_in = 1'b1;
               acc_in = '0;
               bsum_in = '0;
               held_in = '0;
               pos_in = '0;
               later_in = 1'b0;
               bytes_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff <= '0;
         bsum_ff <= '0;
         held_ff <= '0;
         pos_ff <= '0;
         later_ff <= 1'b0;
         bytes_ff <= '0;
         poly_lo_ff <= 64'd1;
         poly_hi_ff <= '0;
         fkey_lo_ff <= '0;
         fkey_hi_ff <= '0;
         len_key_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff <= acc_in;
         bsum_ff <= bsum_in;
         held_ff <= held_in;
         pos_ff <= pos_in;
         later_ff <= later_in;
         bytes_ff <= bytes_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POLY_LO: poly_lo_ff <= csr_wdata;
               CSR_POLY_HI: poly_hi_ff <= csr_wdata;
               CSR_FKEY_LO: fkey_lo_ff <= csr_wdata;
               CSR_FKEY_HI: fkey_hi_ff <= csr_wdata;
               CSR_LEN_KEY: len_key_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      total_ff <= total_in;
      word_ff <= word_in;
      vb_ff <= vb_in;
      last_ff <= last_in;
      fin_ff <= fin_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      mstep_ff <= mstep_in;
      fcnt_ff <= fcnt_in;
      macc_ff <= macc_in;
      flow_ff <= flow_in;
      fhigh_ff <= fhigh_in;
      fmix_ff <= fmix_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule
`default_nettype wire

// ----- verif/tb_carryless_universal_string_hash.sv -----
// Testbench: carry-less string hash, directed table then random messages, checked by a predictor.
`default_nettype none
module tb_carryless_universal_string_hash import clush_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;
   localparam int DRAIN = 120;

   typedef struct {
      bit        cmd;
      bit [6:0]  kidx;
      bit [63:0] data;
      bit [3:0]  vb;
      bit        last;
      bit        known;
      bit [63:0] hash;
   } row_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic              req_cmd = 0;
   logic [6:0]        req_key_index = '0;
   logic [63:0]       req_word_data = '0;
   logic [3:0]        req_valid_bytes = '0;
   logic              req_last_word = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [63:0]       rsp_hash_value;
   logic              csr_wr_en = 0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [63:0]       csr_wdata = '0;

   carryless_universal_string_hash u_top (.*);

   always #2 clock = ~clock;

   // predictor state
   bit [63:0]  m_poly_lo, m_poly_hi, m_fkey_lo, m_fkey_hi, m_len_key;
   bit [63:0]  m_keys [KEY_DEPTH];
   bit [127:0] m_acc, m_bsum;
   bit [63:0]  m_even, m_bytes;
   int         m_pos;
   bit         m_folded;

   bit [63:0] hash_q [$];
   int        errors = 0, cycles = 0, words_sent = 0, hashes_seen = 0, long_msgs = 0;
   bit        calm = 0, hold_kick = 0;
   int        hold_cnt = 0;

   function automatic bit [127:0] clmul(bit [63:0] a, bit [63:0] b);
      bit [127:0] r = '0;
      for (int i = 0; i < 64; i++)
         if (b[i]) r ^= {64'd0, a} << i;
      return r;
   endfunction

   function automatic bit [127:0] poly_fold(bit [127:0] acc);
      bit [63:0]  p0, p1, hl, hh;
      bit [127:0] lo, hi, mix;
      p0 = m_poly_lo;
      p1 = m_poly_hi & POLY_HI_MASK;
      lo = clmul(p0, acc[63:0]);
      hi = clmul(p1, acc[127:64]);
      mix = clmul(p0, acc[127:64]) ^ clmul(p1, acc[63:0]);
      lo[127:64] ^= mix[63:0];
      hi[63:0] ^= mix[127:64];
      hl = hi[63:0];
      hh = hi[127:64];
      return {lo[127:64] ^ (hh << 1) ^ (hl >> 63) ^ (hh << 2) ^ (hl >> 62),
              lo[63:0] ^ (hl << 1) ^ (hl << 2)};
   endfunction

   function automatic bit [63:0] gf_reduce(bit [127:0] a);
      bit [127:0] q;
      q = clmul(a[127:64], 64'h1b);
      return q[63:0] ^ a[63:0] ^ {56'd0, FOLD_TABLE[q[67:64]]};
   endfunction

   function automatic void pair_close();
      if (m_pos[0]) m_bsum ^= clmul(m_even, m_keys[m_pos % KEY_DEPTH]);
   endfunction

   // returns 1 when the item completes a message
   function automatic bit hash_step(row_type it, output bit [63:0] h);
      bit [3:0]   n;
      bit [63:0]  w;
      bit [127:0] t;
      h = '0;
      if (!it.cmd) begin
         m_keys[it.kidx] = it.data;
         return 0;
      end
      n = (it.vb > 8) ? 4'd8 : it.vb;
      if (n == 0 && !it.last) return 0;
      if (n != 0) begin
         w = (n == 8) ? it.data : it.data & ((64'd1 << (8 * n)) - 1);
         if (m_pos >= 128) begin
            pair_close();
            m_acc = m_folded ? poly_fold(m_acc) ^ m_bsum : m_bsum;
            m_folded = 1;
            m_bsum = '0;
            m_pos = 0;
         end
         w ^= m_keys[m_pos % KEY_DEPTH];
         if (m_pos[0]) m_bsum ^= clmul(m_even, w);
         else m_even = w;
         m_pos++;
         m_bytes += n;
      end
      if (!it.last) return 0;
      pair_close();
      if (m_folded) begin
         t = poly_fold(m_acc) ^ m_bsum;
         t ^= {m_fkey_hi, m_fkey_lo};
         t = clmul(t[63:0], t[127:64]);
      end else begin
         t = m_bsum;
      end
      h = gf_reduce(t ^ clmul(m_bytes, m_len_key));
      m_acc = '0; m_bsum = '0; m_even = '0; m_pos = 0; m_folded = 0; m_bytes = '0;
      return 1;
   endfunction

   task automatic send(row_type it);
      bit [63:0] h;
      if (!calm && $urandom_range(99) < 17) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= it.cmd;
      req_key_index <= it.kidx;
      req_word_data <= it.data;
      req_valid_bytes <= it.vb;
      req_last_word <= it.last;
      do @(posedge clock); while (req_stall);
      if (hash_step(it, h)) hash_q.push_back(it.known ? it.hash : h);
      if (it.cmd) words_sent++;
   endtask

   // the caller drops csr_wr_en after the last write of a burst
   task automatic csr_write(logic [CSR_IW-1:0] idx, bit [63:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_POLY_LO: m_poly_lo = v;
         CSR_POLY_HI: m_poly_hi = v;
         CSR_FKEY_LO: m_fkey_lo = v;
         CSR_FKEY_HI: m_fkey_hi = v;
         CSR_LEN_KEY: m_len_key = v;
         default: ;
      endcase
   endtask

   task automatic settle();
      req_valid <= 0;
      while (hash_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic bit [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_message(int nwords);
      row_type it;
      if (nwords > 128) long_msgs++;
      for (int i = 0; i <= nwords; i++) begin
         it = '{default: 0};
         it.kidx = 7'($urandom);
         it.data = rnd64();
         if ($urandom_range(99) < 5) begin
            // noise: key reload or empty word
            it.cmd = 1'($urandom_range(1));
            it.vb = 0;
            it.last = 0;
            send(it);
         end
         if (i == nwords) break;
         it.cmd = 1;
         it.last = (i == nwords - 1);
         case ($urandom_range(19)) inside
            [0:1]:   it.vb = 4'($urandom_range(1, 7));
            2:       it.vb = 4'($urandom_range(9, 15));
            default: it.vb = 8;
         endcase
         if (it.last && $urandom_range(3) == 0) it.vb = 4'($urandom_range(0, 15));
         send(it);
      end
   endtask

   // response side: random stall, checking and a long hold-off on request
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hash_q.size() == 0) begin
            $error("unexpected hash_value %h", rsp_hash_value);
            errors <= errors + 1;
         end else begin
            if (rsp_hash_value !== hash_q[0]) begin
               $error("hash_value expected %h actual %h", hash_q[0], rsp_hash_value);
               errors <= errors + 1;
            end
            void'(hash_q.pop_front());
            hashes_seen <= hashes_seen + 1;
         end
      end
      if (hold_kick && hold_cnt == 0) begin
         hold_cnt <= 400;
         hold_kick <= 0;
         rsp_stall <= 1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= (hold_cnt > 1);
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 17);
      end
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   row_type table_rows [] = '{
      '{1, 0, 64'h0, 0, 1, 1, 64'h0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0},
      '{1, 0, 64'h0, 0, 1, 1, 64'h0},
      '{0, 0, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0},
      '{0, 127, 64'hffff_ffff_ffff_ffff, 15, 1, 0, 0},
      '{1, 127, 64'hffff_ffff_ffff_ffff, 8, 1, 0, 0},
      '{1, 0, 64'h0, 8, 1, 0, 0},
      '{1, 0, 64'h8000_0000_0000_0001, 8, 0, 0, 0},
      '{1, 0, 64'h0123_4567_89ab_cdef, 8, 1, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 1, 1, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 7, 1, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 9, 1, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 15, 1, 0, 0},
      '{1, 0, 64'hdead_beef_cafe_f00d, 3, 0, 0, 0},
      '{1, 0, 64'h1111_2222_3333_4444, 0, 0, 0, 0},
      '{1, 0, 64'h5555_aaaa_5555_aaaa, 8, 0, 0, 0},
      '{1, 0, 64'h0, 0, 1, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 8, 0, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 8, 0, 0, 0},
      '{1, 0, 64'hffff_ffff_ffff_ffff, 5, 1, 0, 0}
   };

   initial begin
      row_type it;
      bit [63:0] cfg [5];
      m_poly_lo = 1; m_poly_hi = 0; m_fkey_lo = 0; m_fkey_hi = 0; m_len_key = 0;
      m_acc = '0; m_bsum = '0; m_even = '0; m_pos = 0; m_folded = 0; m_bytes = '0;
      foreach (m_keys[i]) m_keys[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // every key entry is written before any message reads it
      for (int k = 0; k < KEY_DEPTH; k++) begin
         it = '{default: 0};
         it.kidx = 7'(k);
         it.data = rnd64();
         send(it);
      end
      foreach (table_rows[i]) send(table_rows[i]);
      send_message(130);
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0: cfg = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                       64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                       64'hffff_ffff_ffff_ffff};
            1: cfg = '{rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
            2: cfg = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
            default: cfg = '{rnd64(), rnd64(), rnd64(), rnd64(), 64'h1};
         endcase
         csr_write(CSR_POLY_LO, cfg[0]);
         csr_write(CSR_POLY_HI, cfg[1]);
         csr_write(CSR_FKEY_LO, cfg[2]);
         csr_write(CSR_FKEY_HI, cfg[3]);
         csr_write(CSR_LEN_KEY, cfg[4]);
         csr_wr_en <= 0;
         calm = (ph == 1);
         if (ph == 2) hold_kick = 1;
         while (words_sent < 300 + (ph + 1) * 370) begin
            case ($urandom_range(99)) inside
               [0:2]:   send_message(0);
               [3:14]:  send_message($urandom_range(125, 260));
               default: send_message($urandom_range(1, 24));
            endcase
         end
      end
      calm = 0;
      settle();
      $display("Covered %0d message words and %0d hashes (%0d spanning several blocks),",
               words_sent, hashes_seen, long_msgs);
      $display("over reset, all-ones, zero and random key settings with random stalls.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
